FILE: rtl/selective_scan_step_core_defines.svh
// Assertion macros shared by the selective scan step RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SELECTIVE_SCAN_STEP_CORE_DEFINES_SVH
`define SELECTIVE_SCAN_STEP_CORE_DEFINES_SVH
`ifndef SYNTH
`define SSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSS_ASSERT_IMP(lbl, ante, cons, msg)
`define SSS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/sss_pkg.sv
`default_nettype none
package sss_pkg;

  localparam int LAYER_W = 3;
  localparam int CHAN_W  = 10;
  localparam int SIDX_W  = 4;
  localparam int Q_W     = 32;

  localparam int Q_ONE          = 65536;
  localparam int SOFTPLUS_LIMIT = 1310720;
  localparam int LOG2E_Q        = 94548;
  localparam int EXP_C2         = 5184;
  localparam int EXP_C1         = 14752;
  localparam int EXP_C0         = 45600;
  localparam int LOG_C3         = 10623;
  localparam int LOG_C2         = 30697;
  localparam int LOG_C1         = 65503;
  localparam int DIV_STEPS      = 33;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SAT_W  = 68;
  localparam int POLY_W = 17;
  localparam int REM_W  = 18;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_READ,
    OP_EXP_T,
    OP_EXP_P1,
    OP_EXP_P2,
    OP_EXP_P3,
    OP_EXP_FIN,
    OP_LOG1,
    OP_LOG2,
    OP_LOG3,
    OP_DTA,
    OP_DB,
    OP_DBX,
    OP_H,
    OP_HC,
    OP_SX,
    OP_DIV,
    OP_SILU,
    OP_Y,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    SRC_DT,
    SRC_A,
    SRC_DEC,
    SRC_GATE
  } exp_src_t;

  typedef struct packed {
    op_t      op;
    exp_src_t src;
    logic     div_first;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } stat_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [Q_W-1:0] res;
    if (!v[SAT_W-1] && (|v[SAT_W-2:Q_W-1])) begin
      res = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v[SAT_W-1] && !(&v[SAT_W-2:Q_W-1])) begin
      res = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      res = v[Q_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sss_in_if.sv
`default_nettype none
interface sss_in_if;
  import sss_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [LAYER_W-1:0]      layer;
  logic [CHAN_W-1:0]       channel;
  logic [SIDX_W-1:0]       state_index;
  logic signed [Q_W-1:0]   dt_raw;
  logic signed [Q_W-1:0]   a_log_value;
  logic signed [Q_W-1:0]   b_value;
  logic signed [Q_W-1:0]   c_value;
  logic signed [Q_W-1:0]   x_conv;
  logic signed [Q_W-1:0]   skip_gain;
  logic signed [Q_W-1:0]   gate;
  logic                    last_state;

  modport source (
    output valid, layer, channel, state_index, dt_raw, a_log_value, b_value, c_value,
    output x_conv, skip_gain, gate, last_state,
    input  ready
  );
  modport sink (
    input  valid, layer, channel, state_index, dt_raw, a_log_value, b_value, c_value,
    input  x_conv, skip_gain, gate, last_state,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/sss_out_if.sv
`default_nettype none
interface sss_out_if;
  import sss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [LAYER_W-1:0]    out_layer;
  logic [CHAN_W-1:0]     out_channel;
  logic signed [Q_W-1:0] y_value;

  modport source (output valid, out_layer, out_channel, y_value, input ready);
  modport sink (input valid, out_layer, out_channel, y_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/selective_scan_step_core.sv
// Selective scan step core: one (layer, channel, state index) element per input item.
// Input channel in_ch carries the element operands in signed Q16.16; output channel
// out_ch carries one gated result (layer, channel, y_value) for each item marked
// last_state. Both use valid/ready; an item moves when both are high on a clock edge.
// An element holds the core from its accepting edge to the earliest accept of the next,
// with in_ch.ready low in between; an element with last_state also holds it through the
// skip term, the gate exp, the bit-serial reciprocal for silu and the output step. The
// work is a chain of steps through one shared 33x33 multiplier, and the exp
// approximation alone takes five of them, four times for a last element.
// Reset (rst_n low, synchronous) clears the running sum and starts a pass that writes
// zero to every hidden store entry, one per cycle, with in_ch.ready low: there are
// LAYERS*CHANNELS*STATE_SIZE entries (131072 at the defaults).
// The result sits in an output register; the next element is accepted and worked on
// while it waits. If the receiver still stalls when the following result is ready,
// the core holds that result and keeps in_ch.ready low until the register frees.
`default_nettype none
module selective_scan_step_core #(
  parameter int LAYERS     = 8,
  parameter int CHANNELS   = 1024,
  parameter int STATE_SIZE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sss_in_if.sink     in_ch,
  sss_out_if.source  out_ch
);
  import sss_pkg::*;

  localparam int DEPTH  = LAYERS * CHANNELS * STATE_SIZE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t              cmd;
  stat_t             stat;
  logic              in_ready;
  logic [ADDR_W-1:0] clr_addr;

  sss_ctrl #(.LAYERS(LAYERS), .CHANNELS(CHANNELS), .STATE_SIZE(STATE_SIZE)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .clr_addr (clr_addr)
  );

  sss_dp #(.LAYERS(LAYERS), .CHANNELS(CHANNELS), .STATE_SIZE(STATE_SIZE)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .clr_addr (clr_addr),
    .in_ready (in_ready),
    .stat     (stat),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );
endmodule
`default_nettype wire

FILE: rtl/sss_ram.sv
`default_nettype none
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 131072,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

FILE: rtl/sss_ctrl.sv
`default_nettype none
`include "selective_scan_step_core_defines.svh"
module sss_ctrl #(
  parameter int LAYERS     = 8,
  parameter int CHANNELS   = 1024,
  parameter int STATE_SIZE = 16,
  localparam int DEPTH  = LAYERS * CHANNELS * STATE_SIZE,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sss_pkg::stat_t     stat,
  output sss_pkg::cmd_t      cmd,
  output logic [ADDR_W-1:0]  clr_addr
);
  import sss_pkg::*;

  localparam int DIV_CW = $clog2(DIV_STEPS);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_READ,
    S_EXP_T, S_EXP_P1, S_EXP_P2, S_EXP_P3, S_EXP_FIN,
    S_LOG1, S_LOG2, S_LOG3, S_DTA, S_DB, S_DBX, S_H, S_HC,
    S_SX, S_DIV, S_SILU, S_Y
  } state_t;

  state_t              state_r;
  exp_src_t            phase_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [DIV_CW-1:0]   div_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      phase_r   <= SRC_DT;
      clr_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_READ;
            phase_r <= SRC_DT;
          end
        end
        S_READ:    state_r <= S_EXP_T;
        S_EXP_T:   state_r <= S_EXP_P1;
        S_EXP_P1:  state_r <= S_EXP_P2;
        S_EXP_P2:  state_r <= S_EXP_P3;
        S_EXP_P3:  state_r <= S_EXP_FIN;
        S_EXP_FIN: begin
          unique case (phase_r)
            SRC_DT:   state_r <= S_LOG1;
            SRC_A:    state_r <= S_DTA;
            SRC_DEC:  state_r <= S_DB;
            SRC_GATE: state_r <= S_DIV;
            default:  state_r <= S_IDLE;
          endcase
        end
        S_LOG1: state_r <= S_LOG2;
        S_LOG2: state_r <= S_LOG3;
        S_LOG3: begin
          state_r <= S_EXP_T;
          phase_r <= SRC_A;
        end
        S_DTA: begin
          state_r <= S_EXP_T;
          phase_r <= SRC_DEC;
        end
        S_DB:  state_r <= S_DBX;
        S_DBX: state_r <= S_H;
        S_H:   state_r <= S_HC;
        S_HC:  state_r <= stat.last ? S_SX : S_IDLE;
        S_SX: begin
          state_r <= S_EXP_T;
          phase_r <= SRC_GATE;
        end
        S_DIV: begin
          if (div_cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
            div_cnt_r <= '0;
            state_r   <= S_SILU;
          end else begin
            div_cnt_r <= div_cnt_r + 1'b1;
          end
        end
        S_SILU: state_r <= S_Y;
        S_Y: begin
          // hold until the output register is free
          if (!stat.out_busy) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.src       = phase_r;
    cmd.div_first = (div_cnt_r == '0);
    unique case (state_r)
      S_CLEAR:   cmd.op = OP_CLEAR;
      S_IDLE:    cmd.op = OP_CAPTURE;
      S_READ:    cmd.op = OP_READ;
      S_EXP_T:   cmd.op = OP_EXP_T;
      S_EXP_P1:  cmd.op = OP_EXP_P1;
      S_EXP_P2:  cmd.op = OP_EXP_P2;
      S_EXP_P3:  cmd.op = OP_EXP_P3;
      S_EXP_FIN: cmd.op = OP_EXP_FIN;
      S_LOG1:    cmd.op = OP_LOG1;
      S_LOG2:    cmd.op = OP_LOG2;
      S_LOG3:    cmd.op = OP_LOG3;
      S_DTA:     cmd.op = OP_DTA;
      S_DB:      cmd.op = OP_DB;
      S_DBX:     cmd.op = OP_DBX;
      S_H:       cmd.op = OP_H;
      S_HC:      cmd.op = OP_HC;
      S_SX:      cmd.op = OP_SX;
      S_DIV:     cmd.op = OP_DIV;
      S_SILU:    cmd.op = OP_SILU;
      S_Y:       cmd.op = stat.out_busy ? OP_NONE : OP_Y;
      default:   cmd.op = OP_NONE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign clr_addr = clr_cnt_r;

  `SSS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `SSS_ASSERT_IMP(a_div_bound, state_r == S_DIV, div_cnt_r < DIV_CW'(DIV_STEPS), "div count")
endmodule
`default_nettype wire

FILE: rtl/sss_dp.sv
`default_nettype none
`include "selective_scan_step_core_defines.svh"
module sss_dp #(
  parameter int LAYERS     = 8,
  parameter int CHANNELS   = 1024,
  parameter int STATE_SIZE = 16,
  localparam int DEPTH  = LAYERS * CHANNELS * STATE_SIZE,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sss_pkg::cmd_t     cmd,
  input  logic [ADDR_W-1:0] clr_addr,
  input  logic              in_ready,
  output sss_pkg::stat_t    stat,
  sss_in_if.sink            in_ch,
  sss_out_if.source         out_ch
);
  import sss_pkg::*;

  // captured item
  logic [LAYER_W-1:0]    layer_r;
  logic [CHAN_W-1:0]     chan_r;
  logic [SIDX_W-1:0]     sidx_r;
  logic signed [Q_W-1:0] dt_raw_r, alog_r, b_r, c_r, x_r, skip_r, gate_r;
  logic                  last_r;
  logic [ADDR_W-1:0]     addr_r;
  logic                  valid_r;

  // working registers
  logic signed [5:0]       k_r;
  logic                    kbig_r, ksmall_r;
  logic [15:0]             f_r;
  logic [POLY_W-1:0]       p_r;
  logic signed [Q_W-1:0]   e_r, dt_r, dta_r, tmp_r, dbx_r, h_r, sum_r, sil_r;
  logic signed [MUL_W-1:0] lp_r;
  logic [REM_W-1:0]        rem_r;
  logic [POLY_W-1:0]       q_r;

  logic                  out_valid_r;
  logic [LAYER_W-1:0]    out_layer_r;
  logic [CHAN_W-1:0]     out_chan_r;
  logic signed [Q_W-1:0] y_r;

  logic signed [MUL_W-1:0]       mul_a, mul_b, exp_arg;
  logic signed [PROD_W-1:0]      prod, psh;
  logic signed [PROD_W-33:0]     kx;
  logic signed [Q_W-1:0]         h_old, h_new, sum_base, sp_val;
  logic [Q_W-1:0]                ram_rdata;
  logic [Q_W-1:0]                exp_val;
  logic [POLY_W-1:0]             s_val;
  logic [REM_W-1:0]              div_d;
  logic [REM_W:0]                div_r2;
  logic [REM_W-1:0]              rem_in;
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [Q_W-1:0]                ram_wdata;
  logic                          in_range;
  logic [ADDR_W-1:0]             in_addr;
  logic [5:0]                    rsh;

  assign in_ch.ready = in_ready;

  assign in_range = (int'(in_ch.layer) < LAYERS) && (int'(in_ch.channel) < CHANNELS) &&
                    (int'(in_ch.state_index) < STATE_SIZE);
  assign in_addr  = ADDR_W'((int'(in_ch.layer) * CHANNELS + int'(in_ch.channel)) *
                            STATE_SIZE + int'(in_ch.state_index));

  always_comb begin
    unique case (cmd.src)
      SRC_DT:   exp_arg = dt_raw_r[Q_W-1] ? MUL_W'(dt_raw_r) : -MUL_W'(dt_raw_r);
      SRC_A:    exp_arg = MUL_W'(alog_r);
      SRC_DEC:  exp_arg = -MUL_W'(dta_r);
      SRC_GATE: exp_arg = gate_r[Q_W-1] ? MUL_W'(gate_r) : -MUL_W'(gate_r);
      default:  exp_arg = '0;
    endcase
  end

  assign h_old    = valid_r ? $signed(ram_rdata) : '0;
  assign s_val    = gate_r[Q_W-1] ? (POLY_W'(Q_ONE) - q_r) : q_r;
  assign sum_base = (sidx_r == '0) ? '0 : sum_r;

  always_comb begin
    unique case (cmd.op)
      OP_EXP_T:  begin mul_a = exp_arg;               mul_b = MUL_W'(LOG2E_Q); end
      OP_EXP_P1: begin mul_a = MUL_W'(EXP_C2);        mul_b = MUL_W'(f_r);     end
      OP_EXP_P2,
      OP_EXP_P3: begin mul_a = MUL_W'(p_r);           mul_b = MUL_W'(f_r);     end
      OP_LOG1:   begin mul_a = MUL_W'(LOG_C3);        mul_b = MUL_W'(e_r);     end
      OP_LOG2,
      OP_LOG3:   begin mul_a = lp_r;                  mul_b = MUL_W'(e_r);     end
      OP_DTA:    begin mul_a = MUL_W'(dt_r);          mul_b = MUL_W'(e_r);     end
      OP_DB:     begin mul_a = MUL_W'(dt_r);          mul_b = MUL_W'(b_r);     end
      OP_DBX:    begin mul_a = MUL_W'(tmp_r);         mul_b = MUL_W'(x_r);     end
      OP_H:      begin mul_a = MUL_W'(e_r);           mul_b = MUL_W'(h_old);   end
      OP_HC:     begin mul_a = MUL_W'(h_r);           mul_b = MUL_W'(c_r);     end
      OP_SX:     begin mul_a = MUL_W'(skip_r);        mul_b = MUL_W'(x_r);     end
      OP_SILU:   begin mul_a = MUL_W'(gate_r);        mul_b = MUL_W'(s_val);   end
      OP_Y:      begin mul_a = MUL_W'(tmp_r);         mul_b = MUL_W'(sil_r);   end
      default:   begin mul_a = '0;                    mul_b = '0;              end
    endcase
  end

  assign prod = mul_a * mul_b;
  // floor of the Q16 product
  assign psh  = prod >>> 16;
  assign kx   = prod[PROD_W-1:32];

  assign h_new  = sat32(SAT_W'(psh) + SAT_W'(dbx_r));
  assign sp_val = sat32(SAT_W'(dt_raw_r[Q_W-1] ? '0 : dt_raw_r) + SAT_W'(psh));

  // 2^f scaled by 2^k; out-of-range exponents were flagged at the first step
  assign rsh = 6'(-k_r);
  always_comb begin
    if (kbig_r) begin
      exp_val = {1'b0, {(Q_W-1){1'b1}}};
    end else if (ksmall_r) begin
      exp_val = '0;
    end else if (!k_r[5]) begin
      exp_val = Q_W'(p_r) << k_r[3:0];
    end else begin
      exp_val = Q_W'(p_r) >> rsh[4:0];
    end
  end

  assign div_d  = REM_W'(Q_ONE) + e_r[REM_W-1:0];
  assign rem_in = cmd.div_first ? '0 : rem_r;
  assign div_r2 = {rem_in, cmd.div_first};

  assign ram_we    = (cmd.op == OP_CLEAR) || ((cmd.op == OP_H) && valid_r);
  assign ram_waddr = (cmd.op == OP_CLEAR) ? clr_addr : addr_r;
  assign ram_wdata = (cmd.op == OP_CLEAR) ? '0 : h_new;

  sss_ram #(.WIDTH(Q_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.op == OP_READ),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        layer_r  <= in_ch.layer;
        chan_r   <= in_ch.channel;
        sidx_r   <= in_ch.state_index;
        dt_raw_r <= in_ch.dt_raw;
        alog_r   <= in_ch.a_log_value;
        b_r      <= in_ch.b_value;
        c_r      <= in_ch.c_value;
        x_r      <= in_ch.x_conv;
        skip_r   <= in_ch.skip_gain;
        gate_r   <= in_ch.gate;
        last_r   <= in_ch.last_state;
        valid_r  <= in_range;
        addr_r   <= in_addr;
      end
      OP_EXP_T: begin
        kbig_r   <= (kx >= 15);
        ksmall_r <= (kx <= -32);
        k_r      <= kx[5:0];
        f_r      <= prod[31:16];
      end
      OP_EXP_P1:  p_r <= POLY_W'(EXP_C1) + POLY_W'(psh);
      OP_EXP_P2:  p_r <= POLY_W'(EXP_C0) + POLY_W'(psh);
      OP_EXP_P3:  p_r <= POLY_W'(Q_ONE) + POLY_W'(psh);
      OP_EXP_FIN: e_r <= $signed(exp_val);
      OP_LOG1:    lp_r <= MUL_W'(psh) - MUL_W'(LOG_C2);
      OP_LOG2:    lp_r <= MUL_W'(psh) + MUL_W'(LOG_C1);
      OP_LOG3:    dt_r <= (dt_raw_r > SOFTPLUS_LIMIT) ? dt_raw_r : sp_val;
      OP_DTA:     dta_r <= sat32(SAT_W'(psh));
      OP_DB:      tmp_r <= sat32(SAT_W'(psh));
      OP_DBX:     dbx_r <= sat32(SAT_W'(psh));
      OP_H:       h_r <= h_new;
      OP_SX:      tmp_r <= sat32(SAT_W'(psh) + SAT_W'(sum_r));
      OP_DIV: begin
        if (div_r2 >= {1'b0, div_d}) begin
          rem_r <= REM_W'(div_r2 - {1'b0, div_d});
          q_r   <= {q_r[POLY_W-2:0], 1'b1};
        end else begin
          rem_r <= div_r2[REM_W-1:0];
          q_r   <= {q_r[POLY_W-2:0], 1'b0};
        end
      end
      OP_SILU: sil_r <= sat32(SAT_W'(psh));
      OP_Y: begin
        y_r         <= sat32(SAT_W'(psh));
        out_layer_r <= layer_r;
        out_chan_r  <= chan_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_HC) begin
        sum_r <= sat32(SAT_W'(psh) + SAT_W'(sum_base));
      end
      if (cmd.op == OP_Y) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_layer   = out_layer_r;
  assign out_ch.out_channel = out_chan_r;
  assign out_ch.y_value     = y_r;

  assign stat.last     = last_r;
  assign stat.out_busy = out_valid_r && !out_ch.ready;

  `SSS_ASSERT_IMP(a_y_no_overwrite, cmd.op == OP_Y, !(out_valid_r && !out_ch.ready), "y overwrite")
  `SSS_ASSERT_IMP(a_quot_range, cmd.op == OP_SILU, q_r <= POLY_W'(Q_ONE), "sigmoid range")
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import sss_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    logic [LAYER_W-1:0] layer;
    logic [CHAN_W-1:0]  channel;
    logic [SIDX_W-1:0]  sidx;
    logic signed [Q_W-1:0] dt_raw, a_log, b, c, x, skip, gate;
    logic last;
  } element_t;

  typedef struct {
    logic [LAYER_W-1:0]    layer;
    logic [CHAN_W-1:0]     channel;
    logic signed [Q_W-1:0] y;
  } scan_out_t;

  class scan_scoreboard;
    int hidden[int];
    int acc_sum;
    scan_out_t pending_y[$];
    int errors;

    function new();
      acc_sum = 0;
      errors  = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b) >>> 16;
    endfunction

    function longint q_exp(longint v);
      longint t, u, k, f, p;
      t = v * LOG2E_Q;
      u = t + (64'sd1 <<< 48);
      k = (u >>> 32) - 65536;
      f = (u >>> 16) & 64'hFFFF;
      p = EXP_C2;
      p = EXP_C1 + ((p * f) >>> 16);
      p = EXP_C0 + ((p * f) >>> 16);
      p = Q_ONE + ((p * f) >>> 16);
      if (k >= 15) return 64'sd2147483647;
      if (k >= 0) return clamp32(p <<< k);
      if (k <= -32) return 0;
      return p >>> (-k);
    endfunction

    function longint q_log1p(longint u);
      longint p;
      p = qmul(LOG_C3, u) - LOG_C2;
      p = qmul(p, u) + LOG_C1;
      return qmul(p, u);
    endfunction

    function longint q_softplus(longint v);
      longint av;
      av = (v < 0) ? -v : v;
      if (v > SOFTPLUS_LIMIT) return v;
      return clamp32(((v > 0) ? v : 0) + q_log1p(q_exp(-av)));
    endfunction

    function longint q_silu(longint v);
      longint av, e, s;
      av = (v < 0) ? -v : v;
      e = q_exp(-av);
      s = (64'sd65536 <<< 16) / (Q_ONE + e);
      if (v < 0) s = Q_ONE - s;
      return clamp32(qmul(v, s));
    endfunction

    function void note_element(element_t it);
      int addr;
      longint h_old, dt, a, decay, dbx, h, sum, y;
      scan_out_t r;
      addr  = (int'(it.layer) * 1024 + int'(it.channel)) * 16 + int'(it.sidx);
      h_old = hidden.exists(addr) ? hidden[addr] : 0;
      dt    = q_softplus(it.dt_raw);
      a     = q_exp(it.a_log);
      decay = q_exp(-clamp32(qmul(dt, a)));
      dbx   = clamp32(qmul(clamp32(qmul(dt, it.b)), it.x));
      h     = clamp32(qmul(decay, h_old) + dbx);
      hidden[addr] = int'(h);
      sum = (it.sidx == 0) ? 0 : acc_sum;
      sum = clamp32(sum + qmul(h, it.c));
      acc_sum = int'(sum);
      if (it.last) begin
        y = clamp32(qmul(clamp32(sum + qmul(it.skip, it.x)), q_silu(it.gate)));
        r.layer   = it.layer;
        r.channel = it.channel;
        r.y       = y[31:0];
        pending_y.push_back(r);
      end
    endfunction

    function void check_output(scan_out_t got);
      scan_out_t want;
      if (pending_y.size() == 0) begin
        $error("unexpected output item: layer %0d channel %0d y %0d",
               got.layer, got.channel, got.y);
        errors++;
        return;
      end
      want = pending_y.pop_front();
      if (got.layer !== want.layer) begin
        $error("out_layer: expected %0d, got %0d", want.layer, got.layer);
        errors++;
      end
      if (got.channel !== want.channel) begin
        $error("out_channel: expected %0d, got %0d", want.channel, got.channel);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("y_value: expected %0d, got %0d", want.y, got.y);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  sss_in_if  in_ch ();
  sss_out_if out_ch ();

  selective_scan_step_core u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  scan_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // pick a Q16.16 operand: mostly modest, sometimes edge or full-range
  function automatic logic signed [Q_W-1:0] pick_q();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return $signed($urandom_range(0, 524288)) - 262144;
    if (sel < 75) return $signed($urandom_range(0, 8388608)) - 4194304;
    if (sel < 82) return 32'sh7FFFFFFF;
    if (sel < 89) return 32'sh80000000;
    if (sel < 92) return 0;
    return $signed($urandom);
  endfunction

  function automatic element_t make_element(int lyr, int ch, int si, bit lst);
    element_t e;
    e.layer   = LAYER_W'(lyr);
    e.channel = CHAN_W'(ch);
    e.sidx    = SIDX_W'(si);
    e.dt_raw  = ($urandom_range(0, 9) == 0) ? 32'sd1310721 + $urandom_range(0, 65536)
                                            : pick_q();
    e.a_log   = pick_q();
    e.b       = pick_q();
    e.c       = pick_q();
    e.x       = pick_q();
    e.skip    = pick_q();
    e.gate    = pick_q();
    e.last    = lst;
    return e;
  endfunction

  task automatic send_element(element_t e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.layer       <= e.layer;
    in_ch.channel     <= e.channel;
    in_ch.state_index <= e.sidx;
    in_ch.dt_raw      <= e.dt_raw;
    in_ch.a_log_value <= e.a_log;
    in_ch.b_value     <= e.b;
    in_ch.c_value     <= e.c;
    in_ch.x_conv      <= e.x;
    in_ch.skip_gain   <= e.skip;
    in_ch.gate        <= e.gate;
    in_ch.last_state  <= e.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_element(e);
  endtask

  task automatic send_channel(int lyr, int ch, int len);
    for (int s = 0; s < len; s++) send_element(make_element(lyr, ch, s, s == len - 1));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_y.size() != 0) @(posedge clk);
  endtask

  // output side: check, then choose next ready
  always @(posedge clk) begin
    scan_out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.layer   = out_ch.out_layer;
      got.channel = out_ch.out_channel;
      got.y       = out_ch.y_value;
      sb.check_output(got);
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    element_t e;
    int lyr, ch, len, start;
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    rst_n          <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.layer       <= '0;
    in_ch.channel     <= '0;
    in_ch.state_index <= '0;
    in_ch.dt_raw      <= '0;
    in_ch.a_log_value <= '0;
    in_ch.b_value     <= '0;
    in_ch.c_value     <= '0;
    in_ch.x_conv      <= '0;
    in_ch.skip_gain   <= '0;
    in_ch.gate        <= '0;
    in_ch.last_state  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full extreme-address channel, twice to reuse hidden state
    send_channel(7, 1023, 16);
    send_channel(7, 1023, 3);
    e = make_element(0, 0, 0, 1'b1);
    e.dt_raw = 32'sh7FFFFFFF; e.a_log = 32'sh7FFFFFFF; e.b = 32'sh7FFFFFFF;
    e.c = 32'sh7FFFFFFF; e.x = 32'sh7FFFFFFF; e.skip = 32'sh7FFFFFFF;
    e.gate = 32'sh7FFFFFFF;
    send_element(e);
    e.dt_raw = 32'sh80000000; e.a_log = 32'sh80000000; e.b = 32'sh80000000;
    e.c = 32'sh80000000; e.x = 32'sh80000000; e.skip = 32'sh80000000;
    e.gate = 32'sh80000000;
    send_element(e);
    // softplus boundary, negative gate, last on mid index, sum without restart
    e = make_element(3, 512, 5, 1'b1);
    e.dt_raw = 32'sd1310720; e.gate = -32'sd131072;
    send_element(e);
    e = make_element(3, 512, 6, 1'b1);
    e.dt_raw = 32'sd1310721; e.gate = 32'sd0;
    send_element(e);
    wait_drained();

    for (int i = 0; i < 550; ) begin
      case ((i / 70) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (i > 270 && i < 290) wait_drained();
      lyr = $urandom_range(0, 7);
      ch  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
      len = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 16) : $urandom_range(1, 6);
      if ($urandom_range(0, 9) < 8) begin
        send_channel(lyr, ch, len);
        i += len;
      end else if ($urandom_range(0, 1) == 0) begin
        // broken sequence: start late, maybe never finish
        start = $urandom_range(1, 15);
        for (int s = start; s < 16 && s < start + len; s++) begin
          send_element(make_element(lyr, ch, s, $urandom_range(0, 3) == 0));
          i++;
        end
      end else begin
        e = make_element(lyr, ch, $urandom_range(0, 15), $urandom_range(0, 1) == 1);
        e.layer = LAYER_W'($urandom); e.channel = CHAN_W'($urandom);
        e.dt_raw = $urandom; e.a_log = $urandom; e.b = $urandom; e.c = $urandom;
        e.x = $urandom; e.skip = $urandom; e.gate = $urandom;
        send_element(e);
        i++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_y.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
